/* sv/lidar_point_box_association_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the lidar point box association core
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_BOX_ASSOCIATION_CORE_ASSERT_SVH
`define LIDAR_POINT_BOX_ASSOCIATION_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define LPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LPBA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define LPBA_ASSERT(lbl, prop, msg)
`define LPBA_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* sv/lpba_pkg.sv */
// ----------------------------------------------------------------------------
// lpba_pkg
// Widths, codes and types shared by the point box association core.
// ----------------------------------------------------------------------------
package lpba_pkg;

  localparam int MaxBoxes  = 16;
  localparam int BoxIdxW   = $clog2(MaxBoxes);
  localparam int SlotW     = 4;
  localparam int CoeffW    = 32;
  localparam int CoeffNum  = 12;
  localparam int PointW    = 24;
  localparam int PixW      = 16;
  localparam int BoxW      = 12;
  localparam int ShrinkW   = 8;
  localparam int CountW    = 5;
  localparam int ProdW     = CoeffW + PointW;
  localparam int YW        = ProdW + 2;
  localparam int QBits     = 16;
  localparam int OffShift  = 16;
  // accept edge -> products, pair sums, row sums, prep, divide, saturate, match, output
  localparam int PipeDepth = 3 + 1 + QBits + 1 + 1 + 1;
  localparam int InflW     = $clog2(PipeDepth + 1);

  typedef enum logic [1:0] {
    OpLoadCoeff = 2'd0,
    OpLoadBox   = 2'd1,
    OpClassify  = 2'd2,
    OpSpare     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOne  = 2'd0,
    StNone = 2'd1,
    StMany = 2'd2,
    StZero = 2'd3
  } status_e;

  typedef enum logic {
    CfgShrink = 1'b0,
    CfgCount  = 1'b1
  } cfg_e;

  typedef struct packed {
    logic [BoxW-1:0] left;
    logic [BoxW-1:0] top;
    logic [BoxW-1:0] width;
    logic [BoxW-1:0] height;
  } box_t;

  typedef struct packed {
    logic            zero;
    logic [PixW-1:0] u;
    logic [PixW-1:0] v;
  } pix_t;

endpackage

/* sv/lpba_proj.sv */
// ----------------------------------------------------------------------------
// lpba_proj
// Matrix store and homogeneous projection: products, pair sums, row sums.
// ----------------------------------------------------------------------------
module lpba_proj (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               wr_i,
  input  logic [lpba_pkg::SlotW-1:0]         wr_slot_i,
  input  logic signed [lpba_pkg::CoeffW-1:0] wr_data_i,
  input  logic                               vld_i,
  input  logic signed [lpba_pkg::PointW-1:0] px_i,
  input  logic signed [lpba_pkg::PointW-1:0] py_i,
  input  logic signed [lpba_pkg::PointW-1:0] pz_i,
  output logic                               vld_o,
  output logic signed [lpba_pkg::YW-1:0]     y0_o,
  output logic signed [lpba_pkg::YW-1:0]     y1_o,
  output logic signed [lpba_pkg::YW-1:0]     y2_o
);

  logic signed [lpba_pkg::CoeffW-1:0] mat_q [lpba_pkg::CoeffNum];
  logic signed [lpba_pkg::ProdW-1:0]  prod_q [3][3];
  logic signed [lpba_pkg::CoeffW-1:0] off_q [3];
  logic signed [lpba_pkg::ProdW:0]    pa_q [3];
  logic signed [lpba_pkg::ProdW:0]    pb_q [3];
  logic signed [lpba_pkg::YW-1:0]     y_q [3];
  logic [2:0]                         vld_q;
  logic signed [lpba_pkg::PointW-1:0] pt [3];

  assign pt[0] = px_i;
  assign pt[1] = py_i;
  assign pt[2] = pz_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lpba_pkg::CoeffNum; k++) mat_q[k] <= '0;
    end else if (wr_i && (int'(wr_slot_i) < lpba_pkg::CoeffNum)) begin
      mat_q[wr_slot_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= lpba_pkg::ProdW'(mat_q[i*4+j]) * lpba_pkg::ProdW'(pt[j]);
        end
        off_q[i] <= mat_q[i*4+3];
        pa_q[i]  <= (lpba_pkg::ProdW+1)'(prod_q[i][0]) + (lpba_pkg::ProdW+1)'(prod_q[i][1]);
        pb_q[i]  <= (lpba_pkg::ProdW+1)'(prod_q[i][2])
                  + ((lpba_pkg::ProdW+1)'(off_q[i]) <<< lpba_pkg::OffShift);
        y_q[i]   <= lpba_pkg::YW'(pa_q[i]) + lpba_pkg::YW'(pb_q[i]);
      end
    end
  end

  assign vld_o = vld_q[2];
  assign y0_o  = y_q[0];
  assign y1_o  = y_q[1];
  assign y2_o  = y_q[2];

endmodule

/* sv/lpba_div.sv */
// ----------------------------------------------------------------------------
// lpba_div
// Pipelined restoring divide of two numerators by one depth, one quotient
// bit a stage, then truncation toward zero and 16-bit saturation.
// ----------------------------------------------------------------------------
module lpba_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           vld_i,
  input  logic signed [lpba_pkg::YW-1:0] y0_i,
  input  logic signed [lpba_pkg::YW-1:0] y1_i,
  input  logic signed [lpba_pkg::YW-1:0] y2_i,
  output logic                           vld_o,
  output lpba_pkg::pix_t                 pix_o
);

  localparam int NS = lpba_pkg::QBits + 1;
  localparam int WW = lpba_pkg::YW + lpba_pkg::QBits;
  localparam logic [lpba_pkg::QBits-1:0] PosMax = lpba_pkg::QBits'(32767);
  localparam logic [lpba_pkg::QBits-1:0] NegMax = lpba_pkg::QBits'(32768);

  logic [NS-1:0]                 vld_q;
  logic [lpba_pkg::YW-1:0]       d_q   [NS];
  logic [lpba_pkg::YW-1:0]       ru_q  [NS];
  logic [lpba_pkg::YW-1:0]       rv_q  [NS];
  logic [lpba_pkg::QBits-1:0]    qu_q  [NS];
  logic [lpba_pkg::QBits-1:0]    qv_q  [NS];
  logic [NS-1:0]                 zero_q, negu_q, negv_q, ovfu_q, ovfv_q;
  logic                          vld_out_q;
  lpba_pkg::pix_t                pix_q;

  logic [lpba_pkg::YW-1:0] d_abs, u_abs, v_abs;

  assign d_abs = y2_i[lpba_pkg::YW-1] ? lpba_pkg::YW'(-y2_i) : lpba_pkg::YW'(y2_i);
  assign u_abs = y0_i[lpba_pkg::YW-1] ? lpba_pkg::YW'(-y0_i) : lpba_pkg::YW'(y0_i);
  assign v_abs = y1_i[lpba_pkg::YW-1] ? lpba_pkg::YW'(-y1_i) : lpba_pkg::YW'(y1_i);

  // prep stage: magnitudes, signs and the quotient-too-large test
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q[0]    <= d_abs;
      ru_q[0]   <= u_abs;
      rv_q[0]   <= v_abs;
      qu_q[0]   <= '0;
      qv_q[0]   <= '0;
      zero_q[0] <= (y2_i == '0);
      negu_q[0] <= y0_i[lpba_pkg::YW-1] ^ y2_i[lpba_pkg::YW-1];
      negv_q[0] <= y1_i[lpba_pkg::YW-1] ^ y2_i[lpba_pkg::YW-1];
      ovfu_q[0] <= WW'(u_abs) >= (WW'(d_abs) << lpba_pkg::QBits);
      ovfv_q[0] <= WW'(v_abs) >= (WW'(d_abs) << lpba_pkg::QBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (adv_i) begin
      vld_q     <= {vld_q[NS-2:0], vld_i};
      vld_out_q <= vld_q[NS-1];
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int Sh = lpba_pkg::QBits - k;
    logic                       ge_u, ge_v;
    logic [WW-1:0]              dsh;
    logic [lpba_pkg::QBits-1:0] qu_d, qv_d;

    always_comb begin
      dsh      = WW'(d_q[k-1]) << Sh;
      ge_u     = WW'(ru_q[k-1]) >= dsh;
      ge_v     = WW'(rv_q[k-1]) >= dsh;
      qu_d     = qu_q[k-1];
      qv_d     = qv_q[k-1];
      qu_d[Sh] = ge_u;
      qv_d[Sh] = ge_v;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        d_q[k]    <= d_q[k-1];
        ru_q[k]   <= ge_u ? ru_q[k-1] - lpba_pkg::YW'(dsh) : ru_q[k-1];
        rv_q[k]   <= ge_v ? rv_q[k-1] - lpba_pkg::YW'(dsh) : rv_q[k-1];
        qu_q[k]   <= qu_d;
        qv_q[k]   <= qv_d;
        zero_q[k] <= zero_q[k-1];
        negu_q[k] <= negu_q[k-1];
        negv_q[k] <= negv_q[k-1];
        ovfu_q[k] <= ovfu_q[k-1];
        ovfv_q[k] <= ovfv_q[k-1];
      end
    end
  end

  function automatic logic [lpba_pkg::PixW-1:0] sat_fn(
    input logic [lpba_pkg::QBits-1:0] q,
    input logic                       neg,
    input logic                       ovf
  );
    logic [lpba_pkg::PixW-1:0] r;
    if (neg) begin
      r = (ovf || q > NegMax) ? lpba_pkg::PixW'(NegMax) : lpba_pkg::PixW'(-q);
    end else begin
      r = (ovf || q > PosMax) ? lpba_pkg::PixW'(PosMax) : lpba_pkg::PixW'(q);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pix_q.zero <= zero_q[NS-1];
      pix_q.u    <= zero_q[NS-1] ? '0 : sat_fn(qu_q[NS-1], negu_q[NS-1], ovfu_q[NS-1]);
      pix_q.v    <= zero_q[NS-1] ? '0 : sat_fn(qv_q[NS-1], negv_q[NS-1], ovfv_q[NS-1]);
    end
  end

  assign vld_o = vld_out_q;
  assign pix_o = pix_q;

endmodule

/* sv/lpba_match.sv */
// ----------------------------------------------------------------------------
// lpba_match
// Box store with shrunk edges, parallel containment test and result register.
// ----------------------------------------------------------------------------
module lpba_match (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               wr_i,
  input  logic [lpba_pkg::SlotW-1:0]         wr_slot_i,
  input  lpba_pkg::box_t                     wr_box_i,
  input  logic [lpba_pkg::ShrinkW-1:0]       shrink_i,
  input  logic [lpba_pkg::CountW-1:0]        count_i,
  input  logic                               vld_i,
  input  lpba_pkg::pix_t                     pix_i,
  output logic                               vld_o,
  output logic [1:0]                         status_o,
  output logic [3:0]                         box_index_o,
  output logic [lpba_pkg::PixW-1:0]          pixel_u_o,
  output logic [lpba_pkg::PixW-1:0]          pixel_v_o
);

  localparam int NB = lpba_pkg::MaxBoxes;
  localparam int EW = lpba_pkg::BoxW + 2;
  localparam int CW = lpba_pkg::PixW + 1;

  lpba_pkg::box_t          box_q [NB];
  logic [EW-1:0]           lx_q [NB];
  logic [EW-1:0]           hx_q [NB];
  logic [EW-1:0]           ly_q [NB];
  logic [EW-1:0]           hy_q [NB];
  logic [NB-1:0]           hit_q;
  lpba_pkg::pix_t          pix_q;
  logic                    vld_hit_q, vld_out_q;
  logic [1:0]              status_q;
  logic [3:0]              idx_q;
  logic [lpba_pkg::PixW-1:0] u_q, v_q;

  always_ff @(posedge clk_i) begin
    if (wr_i && (int'(wr_slot_i) < NB)) begin
      box_q[lpba_pkg::BoxIdxW'(wr_slot_i)] <= wr_box_i;
    end
  end

  // shrunk edges follow the table and the shrink register
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NB; k++) begin
      logic [lpba_pkg::BoxW+lpba_pkg::ShrinkW-1:0] sw, sh;
      logic [lpba_pkg::BoxW+lpba_pkg::ShrinkW:0]   kw, kh;
      logic [lpba_pkg::ShrinkW:0]                  keep;
      keep = (lpba_pkg::ShrinkW+1)'(256) - (lpba_pkg::ShrinkW+1)'(shrink_i);
      sw = (lpba_pkg::BoxW+lpba_pkg::ShrinkW)'(shrink_i) * box_q[k].width;
      sh = (lpba_pkg::BoxW+lpba_pkg::ShrinkW)'(shrink_i) * box_q[k].height;
      kw = (lpba_pkg::BoxW+lpba_pkg::ShrinkW+1)'(box_q[k].width) * keep;
      kh = (lpba_pkg::BoxW+lpba_pkg::ShrinkW+1)'(box_q[k].height) * keep;
      lx_q[k] <= EW'(box_q[k].left) + EW'(sw >> 9);
      ly_q[k] <= EW'(box_q[k].top) + EW'(sh >> 9);
      hx_q[k] <= EW'(box_q[k].left) + EW'(sw >> 9) + EW'(kw >> 8);
      hy_q[k] <= EW'(box_q[k].top) + EW'(sh >> 9) + EW'(kh >> 8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_hit_q <= 1'b0;
      vld_out_q <= 1'b0;
    end else if (adv_i) begin
      vld_hit_q <= vld_i;
      vld_out_q <= vld_hit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NB; k++) begin
        logic signed [CW-1:0] u, v;
        u = CW'($signed(pix_i.u));
        v = CW'($signed(pix_i.v));
        hit_q[k] <= (int'(count_i) > k) && !pix_i.zero
                 && u >= $signed({3'b000, lx_q[k]}) && u < $signed({3'b000, hx_q[k]})
                 && v >= $signed({3'b000, ly_q[k]}) && v < $signed({3'b000, hy_q[k]});
      end
      pix_q <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      logic [lpba_pkg::BoxIdxW-1:0] idx;
      idx = '0;
      for (int k = NB - 1; k >= 0; k--) begin
        if (hit_q[k]) idx = lpba_pkg::BoxIdxW'(k);
      end
      u_q <= pix_q.u;
      v_q <= pix_q.v;
      if (pix_q.zero) begin
        status_q <= lpba_pkg::StZero;
        idx_q    <= '0;
      end else if (hit_q == '0) begin
        status_q <= lpba_pkg::StNone;
        idx_q    <= '0;
      end else if ((hit_q & (hit_q - NB'(1))) == '0) begin
        status_q <= lpba_pkg::StOne;
        idx_q    <= 4'(idx);
      end else begin
        status_q <= lpba_pkg::StMany;
        idx_q    <= '0;
      end
    end
  end

  assign vld_o       = vld_out_q;
  assign status_o    = status_q;
  assign box_index_o = idx_q;
  assign pixel_u_o   = u_q;
  assign pixel_v_o   = v_q;

endmodule

/* sv/lidar_point_box_association_core.sv */
// ----------------------------------------------------------------------------
// lidar_point_box_association_core
// Projects lidar points to pixels and names the shrunk box holding them, if only one does.
//
//   channel   direction  handshake                 payload
//   in        request    in_valid_i / in_stall_o   op, slot, coeff, box, point
//   out       result     out_valid_o / out_stall_i status, box_index, pixel u/v
//   cfg       write      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One request per cycle while in_stall_o is low; a point's result passes through the
// projection stages, the 16-stage quotient pipeline, saturation and the matching stages.
// Loads give no result. A box load waits while any point is still in flight.
// Output stall freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the matrix, the pipeline valids, the box count and the in-flight
// count and sets the shrink register to 26; boxes are undefined until loaded.
// ----------------------------------------------------------------------------
`include "lidar_point_box_association_core_assert.svh"

module lidar_point_box_association_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [7:0]                         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         op_i,
  input  logic [3:0]                         slot_i,
  input  logic signed [31:0]                 coeff_value_i,
  input  logic [11:0]                        box_left_i,
  input  logic [11:0]                        box_top_i,
  input  logic [11:0]                        box_width_i,
  input  logic [11:0]                        box_height_i,
  input  logic signed [23:0]                 point_x_i,
  input  logic signed [23:0]                 point_y_i,
  input  logic signed [23:0]                 point_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [3:0]                         box_index_o,
  output logic signed [15:0]                 pixel_u_o,
  output logic signed [15:0]                 pixel_v_o
);

  logic [lpba_pkg::ShrinkW-1:0] shrink_q;
  logic [lpba_pkg::CountW-1:0]  count_q;
  logic [lpba_pkg::InflW-1:0]   infl_q, infl_d;
  logic                         adv, acc, is_pt, pt_acc, out_take;
  logic                         p_vld, d_vld;
  logic signed [lpba_pkg::YW-1:0] y0, y1, y2;
  lpba_pkg::pix_t               pix;
  lpba_pkg::box_t               wbox;
  logic [lpba_pkg::PixW-1:0]    pu, pv;

  assign adv      = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv || (op_i == lpba_pkg::OpLoadBox && infl_q != '0);
  assign acc      = in_valid_i && !in_stall_o;
  assign is_pt    = op_i == lpba_pkg::OpClassify;
  assign pt_acc   = acc && is_pt;
  assign out_take = out_valid_o && !out_stall_i;

  always_comb begin
    infl_d = infl_q;
    if (pt_acc && !out_take) infl_d = infl_q + lpba_pkg::InflW'(1);
    else if (!pt_acc && out_take) infl_d = infl_q - lpba_pkg::InflW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shrink_q <= lpba_pkg::ShrinkW'(26);
      count_q  <= '0;
      infl_q   <= '0;
    end else begin
      infl_q <= infl_d;
      if (cfg_we_i) begin
        case (lpba_pkg::cfg_e'(cfg_index_i))
          lpba_pkg::CfgShrink: shrink_q <= cfg_wdata_i;
          lpba_pkg::CfgCount:  count_q  <= lpba_pkg::CountW'(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

  assign wbox = '{left: box_left_i, top: box_top_i, width: box_width_i,
                  height: box_height_i};

  lpba_proj u_proj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .wr_i      (acc && op_i == lpba_pkg::OpLoadCoeff),
    .wr_slot_i (slot_i),
    .wr_data_i (coeff_value_i),
    .vld_i     (pt_acc),
    .px_i      (point_x_i),
    .py_i      (point_y_i),
    .pz_i      (point_z_i),
    .vld_o     (p_vld),
    .y0_o      (y0),
    .y1_o      (y1),
    .y2_o      (y2)
  );

  lpba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (p_vld),
    .y0_i   (y0),
    .y1_i   (y1),
    .y2_i   (y2),
    .vld_o  (d_vld),
    .pix_o  (pix)
  );

  lpba_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .wr_i        (acc && op_i == lpba_pkg::OpLoadBox),
    .wr_slot_i   (slot_i),
    .wr_box_i    (wbox),
    .shrink_i    (shrink_q),
    .count_i     (count_q),
    .vld_i       (d_vld),
    .pix_i       (pix),
    .vld_o       (out_valid_o),
    .status_o    (status_o),
    .box_index_o (box_index_o),
    .pixel_u_o   (pu),
    .pixel_v_o   (pv)
  );

  assign pixel_u_o = $signed(pu);
  assign pixel_v_o = $signed(pv);

  `LPBA_ASSERT(a_zero_pix, !(out_valid_o && status_o == lpba_pkg::StZero) || (pixel_u_o == '0 && pixel_v_o == '0 && box_index_o == '0), "zero depth with nonzero pixel")
  `LPBA_ASSERT(a_idx_clear, !(out_valid_o && status_o != lpba_pkg::StOne) || box_index_o == '0, "index set without single hit")
  `LPBA_ASSERT(a_idx_range, !(out_valid_o && status_o == lpba_pkg::StOne) || ({1'b0, box_index_o} < count_q), "hit beyond box count")
  `LPBA_ASSERT(a_infl, !out_valid_o || infl_q != '0, "result with nothing in flight")
  `LPBA_ASSERT_NEXT(a_boxload, in_valid_i && op_i == lpba_pkg::OpLoadBox && !in_stall_o, infl_q == '0, "box load overtook a point")

endmodule
